### rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// Used by the top level, the add/subtract unit and the checker; it depends on nothing else.
package stq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int HANDLE_W    = 4;
  localparam int TIME_W      = 32;
  localparam int TARGET_W    = 16;
  localparam int USER_W      = 32;
  localparam int DATA_W      = TARGET_W + USER_W;

  localparam logic [TIME_W-1:0] DUE_LIMIT       = 32'd3221225469;
  localparam logic [TIME_W-1:0] NO_TIMER        = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] MAX_TIMEOUT_RST = 32'd3221225469;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_RESET  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_EXPIRE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [TIME_W-1:0]   a;
    logic [TIME_W-1:0]   b;
  } alu_req_t;

endpackage

### rtl/sorted_timer_queue.sv
// Sorted timer queue top level: sequencer, order list and output register.
// Depends on stq_pkg, stq_ram and stq_alu.
//
// Usage: items arrive on the in_ valid/ready channel, each carrying an action
// (set, reset, cancel or expire) and the current tick. Results leave on the
// out_ valid/ready channel; out_last marks the final result of an item. Set,
// reset and cancel give one result; expire gives one result per fired timer
// and then a final result with the time to the next deadline.
// The block works on one item at a time. in_ready is high only while the
// sequencer is idle, even if the previous final result still waits.
// Steps: a set writes the new deadline, then reads and compares list entries
// one by one during the ordered insertion; a reset of a pending timer first
// searches the list for its entry and removes it. A cancel does the same search
// and removal when the timer is pending. Expire reads and compares the head of
// the list and fires each due timer in turn. The shared add/subtract unit and
// the single read port of the deadline RAM serialize these steps.
// Reset empties the queue, frees all slots and restores max_timeout. When the
// receiver stalls, the sequencer waits before loading the output register.
module sorted_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now,
  input  logic [3:0]  in_handle,
  input  logic        in_handle_valid,
  input  logic [31:0] in_timeout_ms,
  input  logic [15:0] in_target_id,
  input  logic [31:0] in_user_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_result_handle,
  output logic        out_was_pending,
  output logic        out_fired,
  output logic [15:0] out_fired_target,
  output logic [31:0] out_fired_user_data,
  output logic [31:0] out_next_timeout,
  output logic        out_last
);

  localparam int N      = stq_pkg::TIMER_SLOTS;
  localparam int SLOT_W = stq_pkg::SLOT_W;
  localparam int CNT_W  = stq_pkg::CNT_W;
  localparam int HW     = stq_pkg::HANDLE_W;
  localparam int TW     = stq_pkg::TIME_W;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_FIND     = 13'b0000000000100,
    S_REMOVE   = 13'b0000000001000,
    S_WRITE    = 13'b0000000010000,
    S_WRAP     = 13'b0000000100000,
    S_SCAN_RD  = 13'b0000001000000,
    S_SCAN_CMP = 13'b0000010000000,
    S_INSERT   = 13'b0000100000000,
    S_HEAD_RD  = 13'b0001000000000,
    S_HEAD_CMP = 13'b0010000000000,
    S_FIRE     = 13'b0100000000000,
    S_FINAL    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TW-1:0]                 max_timeout_r;
  stq_pkg::act_t                 act_r;
  logic [TW-1:0]                 now_r;
  logic [HW-1:0]                 handle_r;
  logic                          hvalid_r;
  logic [TW-1:0]                 tmo_r;
  logic [stq_pkg::TARGET_W-1:0]  tgt_r;
  logic [stq_pkg::USER_W-1:0]    usr_r;

  logic [SLOT_W-1:0] ol_r [N];
  logic [SLOT_W-1:0] ol_nxt [N];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              wrap_present_r, wrap_present_nxt;
  logic [CNT_W-1:0]  wrap_pos_r, wrap_pos_nxt;
  logic [N-1:0]      used_r, used_nxt;

  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               pending_r, pending_nxt;
  stq_pkg::status_t   status_r, status_nxt;
  logic [HW-1:0]      res_handle_r, res_handle_nxt;
  logic [TW-1:0]      dl_new_r, dl_new_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]   stop_r, stop_nxt;
  logic [TW-1:0]      next_r, next_nxt;

  logic                          out_valid_r, out_valid_nxt;
  stq_pkg::status_t              out_status_r, out_status_nxt;
  logic [HW-1:0]                 out_handle_r, out_handle_nxt;
  logic                          out_pending_r, out_pending_nxt;
  logic                          out_fired_r, out_fired_nxt;
  logic [stq_pkg::TARGET_W-1:0]  out_target_r, out_target_nxt;
  logic [stq_pkg::USER_W-1:0]    out_user_r, out_user_nxt;
  logic [TW-1:0]                 out_next_r, out_next_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                         ram_we;
  logic                         dl_re;
  logic                         dat_re;
  logic [SLOT_W-1:0]            ram_raddr;
  logic [TW-1:0]                dl_rdata;
  logic [stq_pkg::DATA_W-1:0]   dat_rdata;

  stq_pkg::alu_req_t alu_req;
  logic [TW-1:0]     alu_res;
  logic              alu_cout;

  logic [SLOT_W-1:0] free_slot;
  logic              free_found;
  logic [SLOT_W-1:0] handle_slot;
  logic              handle_in_range;
  logic              handle_pending;
  logic              out_free;
  logic              head_due;
  logic              wrapped_now;
  logic [CNT_W-1:0]  wpos_eff;
  logic [SLOT_W-1:0] p_idx;

  stq_alu u_alu (
    .req  (alu_req),
    .res  (alu_res),
    .cout (alu_cout)
  );

  stq_ram #(
    .WIDTH (TW),
    .DEPTH (N)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (alu_res),
    .re    (dl_re),
    .raddr (ram_raddr),
    .rdata (dl_rdata)
  );

  stq_ram #(
    .WIDTH (stq_pkg::DATA_W),
    .DEPTH (N)
  ) u_dat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({tgt_r, usr_r}),
    .re    (dat_re),
    .raddr (ram_raddr),
    .rdata (dat_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_free        = !out_valid_r || out_ready;
  assign handle_slot     = SLOT_W'(32'(handle_r));
  assign handle_in_range = (32'(handle_r) < 32'(N));
  assign handle_pending  = hvalid_r && handle_in_range && used_r[handle_slot];
  assign head_due        = (alu_res == '0) || (alu_res > stq_pkg::DUE_LIMIT);
  assign wrapped_now     = !alu_cout;
  assign wpos_eff        = (wrapped_now && !wrap_present_r) ? cnt_r : wrap_pos_r;
  assign p_idx           = p_r[SLOT_W-1:0];

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    ol_nxt           = ol_r;
    cnt_nxt          = cnt_r;
    wrap_present_nxt = wrap_present_r;
    wrap_pos_nxt     = wrap_pos_r;
    used_nxt         = used_r;
    slot_nxt         = slot_r;
    pending_nxt      = pending_r;
    status_nxt       = status_r;
    res_handle_nxt   = res_handle_r;
    dl_new_nxt       = dl_new_r;
    wrapped_nxt      = wrapped_r;
    p_nxt            = p_r;
    stop_nxt         = stop_r;
    next_nxt         = next_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_handle_nxt   = out_handle_r;
    out_pending_nxt  = out_pending_r;
    out_fired_nxt    = out_fired_r;
    out_target_nxt   = out_target_r;
    out_user_nxt     = out_user_r;
    out_next_nxt     = out_next_r;
    out_last_nxt     = out_last_r;
    alu_req          = '{op: stq_pkg::ALU_SUB, a: '0, b: '0};
    ram_we           = 1'b0;
    dl_re            = 1'b0;
    dat_re           = 1'b0;
    ram_raddr        = ol_r[0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        alu_req        = '{op: stq_pkg::ALU_SUB, a: max_timeout_r, b: tmo_r};
        slot_nxt       = handle_slot;
        pending_nxt    = 1'b0;
        status_nxt     = stq_pkg::ST_OK;
        res_handle_nxt = '0;
        p_nxt          = '0;
        case (act_r)
          stq_pkg::ACT_EXPIRE: begin
            state_nxt = S_HEAD_RD;
          end
          stq_pkg::ACT_CANCEL: begin
            res_handle_nxt = handle_r;
            pending_nxt    = handle_pending;
            state_nxt      = handle_pending ? S_FIND : S_HEAD_RD;
          end
          default: begin
            if (act_r == stq_pkg::ACT_RESET && handle_pending) begin
              pending_nxt = 1'b1;
              state_nxt   = S_FIND;
            end else if (!alu_cout) begin
              status_nxt = stq_pkg::ST_TOO_LARGE;
              state_nxt  = S_HEAD_RD;
            end else if (!free_found) begin
              status_nxt = stq_pkg::ST_FULL;
              state_nxt  = S_HEAD_RD;
            end else begin
              slot_nxt  = free_slot;
              state_nxt = S_WRITE;
            end
          end
        endcase
      end
      S_FIND: begin
        if (p_r < cnt_r && ol_r[p_idx] != slot_r) begin
          p_nxt = p_r + 1'b1;
        end else begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        if (p_r < cnt_r) begin
          for (int i = 0; i < N - 1; i++) begin
            if (CNT_W'(i) >= p_r) begin
              ol_nxt[i] = ol_r[i+1];
            end
          end
          cnt_nxt = cnt_r - 1'b1;
          if (wrap_present_r && p_r < wrap_pos_r) begin
            wrap_pos_nxt = wrap_pos_r - 1'b1;
          end
        end
        if (act_r == stq_pkg::ACT_CANCEL) begin
          used_nxt[slot_r] = 1'b0;
          state_nxt        = S_HEAD_RD;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        alu_req          = '{op: stq_pkg::ALU_ADD, a: now_r, b: tmo_r};
        ram_we           = 1'b1;
        dl_new_nxt       = alu_res;
        used_nxt[slot_r] = 1'b1;
        res_handle_nxt   = HW'(32'(slot_r));
        state_nxt        = S_WRAP;
      end
      S_WRAP: begin
        alu_req          = '{op: stq_pkg::ALU_SUB, a: dl_new_r, b: now_r};
        wrapped_nxt      = wrapped_now;
        wrap_present_nxt = wrap_present_r || wrapped_now;
        wrap_pos_nxt     = wpos_eff;
        p_nxt            = wrapped_now ? wpos_eff : '0;
        stop_nxt         = (!wrapped_now && wrap_present_r) ? wrap_pos_r : cnt_r;
        state_nxt        = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (p_r < stop_r) begin
          dl_re     = 1'b1;
          ram_raddr = ol_r[p_idx];
          state_nxt = S_SCAN_CMP;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_SCAN_CMP: begin
        alu_req = '{op: stq_pkg::ALU_SUB, a: dl_rdata, b: dl_new_r};
        if (!alu_cout) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        for (int i = 1; i < N; i++) begin
          if (CNT_W'(i) > p_r) begin
            ol_nxt[i] = ol_r[i-1];
          end
        end
        for (int i = 0; i < N; i++) begin
          if (CNT_W'(i) == p_r) begin
            ol_nxt[i] = slot_r;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (!wrapped_r && wrap_present_r) begin
          wrap_pos_nxt = wrap_pos_r + 1'b1;
        end
        state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        if (cnt_r == '0) begin
          next_nxt  = stq_pkg::NO_TIMER;
          state_nxt = S_FINAL;
        end else begin
          dl_re     = 1'b1;
          dat_re    = 1'b1;
          ram_raddr = ol_r[0];
          state_nxt = S_HEAD_CMP;
        end
      end
      S_HEAD_CMP: begin
        alu_req = '{op: stq_pkg::ALU_SUB, a: dl_rdata, b: now_r};
        if (act_r == stq_pkg::ACT_EXPIRE && head_due) begin
          state_nxt = S_FIRE;
        end else begin
          next_nxt  = head_due ? '0 : alu_res;
          state_nxt = S_FINAL;
        end
      end
      S_FIRE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = stq_pkg::ST_OK;
          out_handle_nxt  = HW'(32'(ol_r[0]));
          out_pending_nxt = 1'b0;
          out_fired_nxt   = 1'b1;
          out_target_nxt  = dat_rdata[stq_pkg::DATA_W-1:stq_pkg::USER_W];
          out_user_nxt    = dat_rdata[stq_pkg::USER_W-1:0];
          out_next_nxt    = '0;
          out_last_nxt    = 1'b0;
          used_nxt[ol_r[0]] = 1'b0;
          for (int i = 0; i < N - 1; i++) begin
            ol_nxt[i] = ol_r[i+1];
          end
          cnt_nxt = cnt_r - 1'b1;
          if (wrap_present_r) begin
            if (wrap_pos_r == '0) begin
              wrap_present_nxt = 1'b0;
            end else begin
              wrap_pos_nxt = wrap_pos_r - 1'b1;
            end
          end
          state_nxt = S_HEAD_RD;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_handle_nxt  = res_handle_r;
          out_pending_nxt = pending_r;
          out_fired_nxt   = 1'b0;
          out_target_nxt  = '0;
          out_user_nxt    = '0;
          out_next_nxt    = next_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      max_timeout_r  <= stq_pkg::MAX_TIMEOUT_RST;
      cnt_r          <= '0;
      wrap_present_r <= 1'b0;
      wrap_pos_r     <= '0;
      used_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      wrap_present_r <= wrap_present_nxt;
      wrap_pos_r     <= wrap_pos_nxt;
      used_r         <= used_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r    <= stq_pkg::act_t'(in_action);
      now_r    <= in_now;
      handle_r <= in_handle;
      hvalid_r <= in_handle_valid;
      tmo_r    <= in_timeout_ms;
      tgt_r    <= in_target_id;
      usr_r    <= in_user_data;
    end
    ol_r          <= ol_nxt;
    slot_r        <= slot_nxt;
    pending_r     <= pending_nxt;
    status_r      <= status_nxt;
    res_handle_r  <= res_handle_nxt;
    dl_new_r      <= dl_new_nxt;
    wrapped_r     <= wrapped_nxt;
    p_r           <= p_nxt;
    stop_r        <= stop_nxt;
    next_r        <= next_nxt;
    out_status_r  <= out_status_nxt;
    out_handle_r  <= out_handle_nxt;
    out_pending_r <= out_pending_nxt;
    out_fired_r   <= out_fired_nxt;
    out_target_r  <= out_target_nxt;
    out_user_r    <= out_user_nxt;
    out_next_r    <= out_next_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_handle   = out_handle_r;
  assign out_was_pending     = out_pending_r;
  assign out_fired           = out_fired_r;
  assign out_fired_target    = out_target_r;
  assign out_fired_user_data = out_user_r;
  assign out_next_timeout    = out_next_r;
  assign out_last            = out_last_r;

endmodule

### rtl/stq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; the timer queue uses it for deadlines and timer data.
module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/stq_alu.sv
// Shared 32-bit add/subtract unit of the timer queue sequencer.
// Depends on stq_pkg for the request struct.
module stq_alu (
  input  stq_pkg::alu_req_t                req,
  output logic [stq_pkg::TIME_W-1:0]       res,
  output logic                             cout
);

  logic [stq_pkg::TIME_W:0]   sum;
  logic [stq_pkg::TIME_W-1:0] b_op;

  // For a subtraction, cout low means a was below b.
  assign b_op = (req.op == stq_pkg::ALU_SUB) ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{stq_pkg::TIME_W{1'b0}},
                                                (req.op == stq_pkg::ALU_SUB)};
  assign res  = sum[stq_pkg::TIME_W-1:0];
  assign cout = sum[stq_pkg::TIME_W];

endmodule

### rtl/stq_checker.sv
// Port-level assertions for the sorted timer queue, bound to its top level.
// Depends on stq_pkg and on the port names of sorted_timer_queue.
module stq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [3:0]  out_result_handle,
  input logic        out_was_pending,
  input logic        out_fired,
  input logic [15:0] out_fired_target,
  input logic [31:0] out_fired_user_data,
  input logic [31:0] out_next_timeout,
  input logic        out_last
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_status, out_result_handle,
      out_was_pending, out_fired, out_fired_target, out_fired_user_data,
      out_next_timeout, out_last}))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  // Every result is either a fired timer or the final result of its item.
  a_fired_or_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last != out_fired))
    else $error("result is neither a fired timer nor a final result");

  // A rejected item names no slot and is always final.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != stq_pkg::ST_OK |->
      out_result_handle == '0 && !out_was_pending && out_last && !out_fired)
    else $error("rejected item result is malformed");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

### dv/tb_sorted_timer_queue.sv
// Self-checking testbench for sorted_timer_queue: directed and random timer
// operations with a cycle-free timer-queue predictor. Depends on stq_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sorted_timer_queue;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    stq_pkg::act_t action;
    logic [31:0]   now;
    logic [3:0]    handle;
    logic          hvalid;
    logic [31:0]   tmo;
    logic [15:0]   target;
    logic [31:0]   user;
  } tq_req_t;

  typedef struct packed {
    stq_pkg::status_t status;
    logic [3:0]       handle;
    logic             was_pending;
    logic             fired;
    logic [15:0]      target;
    logic [31:0]      user;
    logic [31:0]      next_tmo;
    logic             last;
  } tq_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [31:0] in_now = '0;
  logic [3:0]  in_handle = '0;
  logic        in_handle_valid = 1'b0;
  logic [31:0] in_timeout_ms = '0;
  logic [15:0] in_target_id = '0;
  logic [31:0] in_user_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_result_handle;
  logic        out_was_pending;
  logic        out_fired;
  logic [15:0] out_fired_target;
  logic [31:0] out_fired_user_data;
  logic [31:0] out_next_timeout;
  logic        out_last;

  // Predicted queue state.
  logic [3:0]  q_order [stq_pkg::TIMER_SLOTS];
  int          q_count = 0;
  logic        q_wrap = 1'b0;
  int          q_wrap_pos = 0;
  logic        slot_busy [stq_pkg::TIMER_SLOTS] = '{default: 1'b0};
  logic [31:0] slot_due [stq_pkg::TIMER_SLOTS];
  logic [15:0] slot_tgt [stq_pkg::TIMER_SLOTS];
  logic [31:0] slot_usr [stq_pkg::TIMER_SLOTS];
  logic [31:0] max_tmo = stq_pkg::MAX_TIMEOUT_RST;

  tq_reply_t   pending_replies [$];
  tq_reply_t   want;
  logic        no_idle = 1'b0;
  logic [31:0] tick = '0;
  int          mismatches = 0;
  int          replies_checked = 0;
  int          timers_fired = 0;
  int          items_sent = 0;
  int          cfg_writes = 0;
  int          act_count [4] = '{default: 0};

  sorted_timer_queue u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_now              (in_now),
    .in_handle           (in_handle),
    .in_handle_valid     (in_handle_valid),
    .in_timeout_ms       (in_timeout_ms),
    .in_target_id        (in_target_id),
    .in_user_data        (in_user_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_result_handle   (out_result_handle),
    .out_was_pending     (out_was_pending),
    .out_fired           (out_fired),
    .out_fired_target    (out_fired_target),
    .out_fired_user_data (out_fired_user_data),
    .out_next_timeout    (out_next_timeout),
    .out_last            (out_last)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] head_wait(input logic [31:0] now);
    logic [31:0] diff;
    if (q_count == 0) return stq_pkg::NO_TIMER;
    diff = slot_due[q_order[0]] - now;
    return (diff > stq_pkg::DUE_LIMIT) ? 32'd0 : diff;
  endfunction

  function automatic void drop_at(input int pos);
    if (pos >= q_count) return;
    for (int i = pos; i < q_count - 1; i++) q_order[i] = q_order[i + 1];
    q_count--;
    if (q_wrap && pos < q_wrap_pos) q_wrap_pos--;
  endfunction

  function automatic int find_slot(input int slot);
    for (int i = 0; i < q_count; i++) if (q_order[i] == slot) return i;
    return -1;
  endfunction

  function automatic void place_slot(input int slot, input logic [31:0] due,
                                     input logic [31:0] now);
    logic wrapped;
    int   p;
    int   limit_pos;
    wrapped = due < now;
    if (q_count >= stq_pkg::TIMER_SLOTS) return;
    if (wrapped && !q_wrap) begin
      q_wrap = 1'b1;
      q_wrap_pos = q_count;
    end
    p = wrapped ? q_wrap_pos : 0;
    limit_pos = (!wrapped && q_wrap) ? q_wrap_pos : q_count;
    while (p < limit_pos && slot_due[q_order[p]] < due) p++;
    for (int i = q_count; i > p; i--) q_order[i] = q_order[i - 1];
    q_order[p] = 4'(slot);
    q_count++;
    if (!wrapped && q_wrap) q_wrap_pos++;
  endfunction

  function automatic void push_reply(input stq_pkg::status_t st, input logic [3:0] h,
                                     input logic wp, input logic f,
                                     input logic [15:0] tg, input logic [31:0] us,
                                     input logic [31:0] nt, input logic lst);
    tq_reply_t r;
    r = '{status: st, handle: h, was_pending: wp, fired: f, target: tg, user: us,
          next_tmo: nt, last: lst};
    pending_replies.push_back(r);
  endfunction

  function automatic void apply_timer_op(input tq_req_t r);
    logic             pending;
    int               slot;
    int               pos;
    stq_pkg::status_t st;
    pending = r.hvalid && slot_busy[r.handle];
    if (r.action == stq_pkg::ACT_EXPIRE) begin
      while (q_count > 0 && head_wait(r.now) == 0) begin
        if (q_wrap && q_wrap_pos == 0) q_wrap = 1'b0;
        slot = q_order[0];
        drop_at(0);
        slot_busy[slot] = 1'b0;
        push_reply(stq_pkg::ST_OK, 4'(slot), 1'b0, 1'b1, slot_tgt[slot], slot_usr[slot],
                   '0, 1'b0);
      end
      push_reply(stq_pkg::ST_OK, '0, 1'b0, 1'b0, '0, '0, head_wait(r.now), 1'b1);
    end else if (r.action == stq_pkg::ACT_CANCEL) begin
      if (pending) begin
        pos = find_slot(r.handle);
        if (pos >= 0) drop_at(pos);
        slot_busy[r.handle] = 1'b0;
      end
      push_reply(stq_pkg::ST_OK, r.handle, pending, 1'b0, '0, '0, head_wait(r.now), 1'b1);
    end else begin
      st = stq_pkg::ST_OK;
      if (r.action == stq_pkg::ACT_RESET && pending) begin
        pos = find_slot(r.handle);
        if (pos >= 0) drop_at(pos);
        slot = r.handle;
      end else begin
        pending = 1'b0;
        for (slot = 0; slot < stq_pkg::TIMER_SLOTS && slot_busy[slot]; slot++) begin
        end
        if (r.tmo > max_tmo) st = stq_pkg::ST_TOO_LARGE;
        else if (slot >= stq_pkg::TIMER_SLOTS) st = stq_pkg::ST_FULL;
      end
      if (st == stq_pkg::ST_OK) begin
        slot_busy[slot] = 1'b1;
        slot_due[slot] = r.now + r.tmo;
        slot_tgt[slot] = r.target;
        slot_usr[slot] = r.user;
        place_slot(slot, slot_due[slot], r.now);
        push_reply(stq_pkg::ST_OK, 4'(slot), pending, 1'b0, '0, '0, head_wait(r.now), 1'b1);
      end else begin
        push_reply(st, '0, 1'b0, 1'b0, '0, '0, head_wait(r.now), 1'b1);
      end
    end
  endfunction

  function automatic int busy_slots();
    int n;
    n = 0;
    for (int s = 0; s < stq_pkg::TIMER_SLOTS; s++) if (slot_busy[s]) n++;
    return n;
  endfunction

  function automatic tq_req_t make_req(input stq_pkg::act_t a, input logic [3:0] h,
                                       input logic hv, input logic [31:0] tmo,
                                       input logic [15:0] tg, input logic [31:0] us);
    tq_req_t r;
    r = '{action: a, now: tick, handle: h, hvalid: hv, tmo: tmo, target: tg, user: us};
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
  endtask

  task automatic send_item(input tq_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    in_now <= r.now;
    in_handle <= r.handle;
    in_handle_valid <= r.hvalid;
    in_timeout_ms <= r.tmo;
    in_target_id <= r.target;
    in_user_data <= r.user;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_timer_op(r);
    items_sent++;
    act_count[r.action]++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [31:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_tmo = value;
    cfg_writes++;
  endtask

  task automatic test_basic_ops();
    tick = 32'd1000;
    send_item(make_req(stq_pkg::ACT_EXPIRE, 4'd0, 1'b0, '0, '0, '0));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, '0, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, stq_pkg::MAX_TIMEOUT_RST, '0, '0));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, stq_pkg::MAX_TIMEOUT_RST + 1,
                       16'h1, 32'h1));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'd50, 16'h1234, 32'h5566_7788));
    send_item(make_req(stq_pkg::ACT_RESET, 4'd2, 1'b1, 32'hFFFF_FFFF, 16'h4321,
                       32'hA5A5_5A5A));
    send_item(make_req(stq_pkg::ACT_RESET, 4'd1, 1'b0, 32'd30, 16'h8000, 32'h8000_0000));
    send_item(make_req(stq_pkg::ACT_CANCEL, 4'd1, 1'b1, '0, '0, '0));
    send_item(make_req(stq_pkg::ACT_CANCEL, 4'd1, 1'b1, '0, '0, '0));
    send_item(make_req(stq_pkg::ACT_CANCEL, 4'd15, 1'b0, '0, '0, '0));
    tick += 32'd40;
    send_item(make_req(stq_pkg::ACT_EXPIRE, 4'd0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_table_full();
    while (busy_slots() < stq_pkg::TIMER_SLOTS)
      send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, $urandom_range(1, 1000), $urandom,
                         $urandom));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'd10, 16'h0F0F, 32'h0F0F_0F0F));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'hFFFF_FFFF, '0, '0));
    tick += 32'd5000;
    send_item(make_req(stq_pkg::ACT_EXPIRE, 4'd0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_wrap_marker();
    tick = 32'hFFFF_FFF0;
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'h100, 16'h00AA, 32'h0000_00AA));
    send_item(make_req(stq_pkg::ACT_CANCEL, 4'd0, 1'b1, '0, '0, '0));
    send_item(make_req(stq_pkg::ACT_EXPIRE, 4'd0, 1'b0, '0, '0, '0));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'd5, 16'h00BB, 32'h0000_00BB));
  endtask

  task automatic test_config_extremes();
    write_cfg(32'd0);
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'd0, 16'h0C0C, 32'h0C0C_0C0C));
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'd1, 16'h0D0D, 32'h0D0D_0D0D));
    write_cfg(32'hFFFF_FFFF);
    send_item(make_req(stq_pkg::ACT_SET, 4'd0, 1'b0, 32'hFFFF_FFFF, 16'h0E0E,
                       32'h0E0E_0E0E));
  endtask

  task automatic send_random_item();
    int            sel;
    int            busy [$];
    stq_pkg::act_t a;
    logic [3:0]    h;
    logic [31:0]   tmo;
    sel = $urandom_range(0, 99);
    if (sel < 3) tick = $urandom;
    else if (sel < 8) tick += $urandom_range(0, 8000);
    else tick += $urandom_range(0, 40);
    sel = $urandom_range(0, 99);
    a = (sel < 40) ? stq_pkg::ACT_SET : (sel < 55) ? stq_pkg::ACT_RESET :
        (sel < 70) ? stq_pkg::ACT_CANCEL : stq_pkg::ACT_EXPIRE;
    for (int s = 0; s < stq_pkg::TIMER_SLOTS; s++) if (slot_busy[s]) busy.push_back(s);
    if (busy.size() > 0 && $urandom_range(0, 3) != 0)
      h = 4'(busy[$urandom_range(0, busy.size() - 1)]);
    else
      h = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 99);
    if (sel < 35) tmo = $urandom_range(0, 64);
    else if (sel < 60) tmo = $urandom_range(0, 2000);
    else if (sel < 70) tmo = max_tmo;
    else if (sel < 80) tmo = max_tmo + 1;
    else tmo = $urandom;
    send_item(make_req(a, h, $urandom_range(0, 9) != 0, tmo, 16'($urandom), $urandom));
  endtask

  task automatic test_random();
    logic [31:0] settings [8];
    settings = '{stq_pkg::MAX_TIMEOUT_RST, 32'hFFFF_FFFF, 32'd0, $urandom,
                 $urandom_range(0, 3000), stq_pkg::MAX_TIMEOUT_RST, $urandom,
                 32'hFFFF_FFFF};
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(settings[ph]);
      no_idle = (ph % 3 == 2);
      if (ph == 3 || ph == 6) tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      repeat (55) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_replies.size() == 0) begin
        report("unexpected result", {out_fired, out_result_handle}, '0);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (want.fired) timers_fired++;
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_result_handle !== want.handle)
          report("result_handle", out_result_handle, want.handle);
        if (out_was_pending !== want.was_pending)
          report("was_pending", out_was_pending, want.was_pending);
        if (out_fired !== want.fired) report("fired", out_fired, want.fired);
        if (out_fired_target !== want.target)
          report("fired_target", out_fired_target, want.target);
        if (out_fired_user_data !== want.user)
          report("fired_user_data", out_fired_user_data, want.user);
        if (out_next_timeout !== want.next_tmo)
          report("next_timeout", out_next_timeout, want.next_tmo);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, pending_replies.size());
    $display("tb_sorted_timer_queue: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_table_full();
    test_wrap_marker();
    test_config_extremes();
    test_random();
    settle();
    $display("Sent %0d items (set %0d, reset %0d, cancel %0d, expire %0d) over %0d settings.",
             items_sent, act_count[stq_pkg::ACT_SET], act_count[stq_pkg::ACT_RESET],
             act_count[stq_pkg::ACT_CANCEL], act_count[stq_pkg::ACT_EXPIRE], cfg_writes);
    $display("Checked %0d results including %0d fired timers; %0d mismatches.",
             replies_checked, timers_fired, mismatches);
    if (mismatches == 0) begin
      $display("tb_sorted_timer_queue: done, clean");
    end else begin
      $display("tb_sorted_timer_queue: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_alu.sv
rtl/sorted_timer_queue.sv
rtl/stq_checker.sv
dv/tb_sorted_timer_queue.sv
